// ===== rtl/iirl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the indexed insert/remove list: widths, opcodes, status codes
// and the command struct broadcast from the control logic to the cell row.
// No dependencies.
package iirl_pkg;

	// field widths fixed by the word format
	localparam int CNT_W      = 5;
	localparam int WORD_W     = 32;
	localparam int OP_W       = 2;
	localparam int ST_W       = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// build defaults
	localparam int DEPTH_DEF = 16;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ   = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// command seen by every cell in the row
	typedef struct packed {
		logic              shift_up;
		logic              shift_down;
		logic [CNT_W-1:0]  pos;
		logic [WORD_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== rtl/iirl_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list row: holds one entry and loads from its
// lower or upper neighbour, or from the new word, as the command says.
// Depends on iirl_pkg.
module iirl_cell
	import iirl_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [WORD_W-1:0] lower_word,
	input  logic [WORD_W-1:0] upper_word,
	output logic [WORD_W-1:0] word,
	output logic [WORD_W-1:0] hit_word
);

	logic [WORD_W-1:0] data_q;
	logic              above;
	logic              at;

	assign above = int'(cmd.pos) < IDX;
	assign at    = int'(cmd.pos) == IDX;

	// shift up above the index, load the new word at it, or shift down from it
	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (above) begin
				data_q <= lower_word;
			end else if (at) begin
				data_q <= cmd.value;
			end
		end else if (cmd.shift_down) begin
			if (above || at) begin
				data_q <= upper_word;
			end
		end
	end

	assign word     = data_q;
	// offer the entry to the read OR only when it is the addressed cell
	assign hit_word = at ? data_q : '0;

endmodule

// ===== rtl/indexed_insert_remove_list.sv =====
`timescale 1ns / 1ps
// Indexed insert/remove list: one operation per word, result registered on acceptance.
// Throughput: one word per cycle unless a result held for m_tready stalls s_tready;
// every cell shifts, loads or holds in parallel.
// Reset: count cleared, capacity set to 16, no result pending; cell contents
// stay undefined until written. Depends on iirl_pkg and iirl_cell.
module indexed_insert_remove_list
	import iirl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: capacity
	input  logic                  cfg_wr_en,
	input  logic [CNT_W-1:0]      cfg_wr_data,
	// input words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// opcode[1:0], position[6:2], value[38:7], zero fill above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], read_value[33:2], read_valid[34], size_now[39:35],
	// is_full[40], is_empty[41], zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_lim;
	logic              accept;

	logic [OP_W-1:0]   opcode;
	logic [CNT_W-1:0]  position;
	logic [WORD_W-1:0] value;

	logic [ST_W-1:0]   status;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              ins_ok;
	logic              rem_ok;
	logic              rd_ok;
	logic [WORD_W-1:0] rd_word;

	cell_cmd_t         cmd;
	logic [WORD_W-1:0] cell_word [DEPTH];
	logic [WORD_W-1:0] cell_hit  [DEPTH];

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// unpack the input word
	assign opcode   = s_tdata[1:0];
	assign position = s_tdata[6:2];
	assign value    = s_tdata[38:7];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// effective capacity is bounded by the built depth
	assign cap_lim = (int'(cap_q) < DEPTH) ? cap_q : CNT_W'(DEPTH);

	// decode the operation and check the index and fill level
	always_comb begin
		status  = ST_OK;
		cnt_nxt = count_q;
		ins_ok  = 1'b0;
		rem_ok  = 1'b0;
		rd_ok   = 1'b0;
		unique case (opcode)
			OP_CLEAR: begin
				cnt_nxt = '0;
			end
			OP_INSERT: begin
				if (position > count_q) begin
					status = ST_INDEX;
				end else if (count_q >= cap_lim) begin
					status = ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (position >= count_q) begin
					status = ST_INDEX;
				end else begin
					rem_ok  = 1'b1;
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (position >= count_q) begin
					status = ST_INDEX;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// broadcast the command to the row
	assign cmd.shift_up   = accept && ins_ok;
	assign cmd.shift_down = accept && rem_ok;
	assign cmd.pos        = position;
	assign cmd.value      = value;

	// row of cells, each linked to its neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] lower_w;
		logic [WORD_W-1:0] upper_w;
		if (i == 0) begin : g_bottom
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign upper_w = cell_word[i];
		end else begin : g_upper
			assign upper_w = cell_word[i+1];
		end
		iirl_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (cell_word[i]),
			.hit_word   (cell_hit[i])
		);
	end

	// gather the addressed entry
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_hit[i];
		end
	end

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// advance the entry count on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= cnt_nxt;
		end
	end

	// output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {6'd0,
				(cnt_nxt == '0),
				(cnt_nxt >= cap_lim),
				cnt_nxt,
				rd_ok,
				(rd_ok ? rd_word : '0),
				status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
